### src/bordered_rectangle_rasterizer_assert.svh
// Assertion macros used by the rasterizer RTL.
`ifndef BORDERED_RECTANGLE_RASTERIZER_ASSERT_SVH
`define BORDERED_RECTANGLE_RASTERIZER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define BRR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BRR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### src/brr_pkg.sv
// Types and constants of the bordered rectangle rasterizer.
package brr_pkg;

  localparam int SCREEN_W_DEF = 320;
  localparam int SCREEN_H_DEF = 240;

  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int PIX_X_W    = 9;
  localparam int PIX_Y_W    = 8;
  localparam int PIX_ADDR_W = 17;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [COORD_W-1:0]   origin_x_in;
    logic [COORD_W-1:0]   origin_y_in;
    logic [SIZE_W-1:0]    rect_w_in;
    logic [SIZE_W-1:0]    rect_h_in;
    logic [SIZE_W-1:0]    edge_width_in;
    logic [COLOR_W-1:0]   edge_color_in;
    logic [COLOR_W-1:0]   interior_color_in;
    logic                 fill_in;
  } brr_cmd_t;

  typedef struct packed {
    logic [PIX_X_W-1:0]    pix_x;
    logic [PIX_Y_W-1:0]    pix_y;
    logic [PIX_ADDR_W-1:0] pix_addr;
    logic [COLOR_W-1:0]    pix_color;
    logic                  last;
  } brr_pix_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LEFT   = 6'b000010,
    ST_RIGHT  = 6'b000100,
    ST_TOP    = 6'b001000,
    ST_BOTTOM = 6'b010000,
    ST_FILL   = 6'b100000
  } brr_state_t;

endpackage

### src/brr_cmd_if.sv
// Command channel: start and step items.
interface brr_cmd_if;
  logic              valid;
  logic              ready;
  brr_pkg::brr_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/brr_pix_if.sv
// Pixel channel: one framebuffer write per item.
interface brr_pix_if;
  logic              valid;
  logic              ready;
  brr_pkg::brr_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bordered_rectangle_rasterizer.sv
// Bordered rectangle rasterizer: a start item (op = 0) latches a rectangle and
// produces no pixel; each step item (op = 1) then yields one framebuffer write,
// left and right border columns first, then top and bottom border rows, then
// the interior column by column when fill is set; last marks the final pixel.
// Steps while idle are dropped. One item is taken every cycle unless the output
// stalls; a pixel passes through the walker register and then the address
// register that holds the y*(SCREEN_W+1)+x multiply result.
`include "bordered_rectangle_rasterizer_assert.svh"

module bordered_rectangle_rasterizer #(
  parameter int SCREEN_W = brr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = brr_pkg::SCREEN_H_DEF
) (
  input  logic      clk,
  input  logic      rst,
  brr_cmd_if.sink   cmd,
  brr_pix_if.source pix
);

  localparam int XW = $clog2(SCREEN_W);
  localparam int YW = $clog2(SCREEN_H);

  logic                        busy;
  logic                        pt_valid, pt_ready, pt_last;
  logic [XW-1:0]               pt_x;
  logic [YW-1:0]               pt_y;
  logic [brr_pkg::COLOR_W-1:0] pt_col;
  logic                        step_fire;

  brr_stepper #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_stepper (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .busy    (busy),
    .pt_valid(pt_valid),
    .pt_ready(pt_ready),
    .pt_x    (pt_x),
    .pt_y    (pt_y),
    .pt_col  (pt_col),
    .pt_last (pt_last)
  );

  brr_addr_stage #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_addr (
    .clk     (clk),
    .rst     (rst),
    .pt_valid(pt_valid),
    .pt_ready(pt_ready),
    .pt_x    (pt_x),
    .pt_y    (pt_y),
    .pt_col  (pt_col),
    .pt_last (pt_last),
    .pix     (pix)
  );

  assign step_fire = cmd.valid && cmd.ready && (cmd.data.op == brr_pkg::OP_STEP) && busy;

  `BRR_ASSERT_NEXT(a_last_matches_idle, clk, rst, step_fire, pt_valid && (pt_last == !busy), "last flag disagrees with walker state")
  `BRR_ASSERT_IMPL(a_point_on_screen, clk, rst, pt_valid, (int'(pt_x) < SCREEN_W) && (int'(pt_y) < SCREEN_H), "pixel coordinate off screen")
  `BRR_ASSERT_IMPL(a_ready_when_drained, clk, rst, !pix.valid, cmd.ready, "input stalled with empty output")

endmodule

### src/brr_stepper.sv
// Rectangle walker: latches a rectangle, steps through border and fill pixels.
module brr_stepper #(
  parameter int SCREEN_W = brr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = brr_pkg::SCREEN_H_DEF,
  localparam int XW = $clog2(SCREEN_W),
  localparam int YW = $clog2(SCREEN_H)
) (
  input  logic                        clk,
  input  logic                        rst,
  brr_cmd_if.sink                     cmd,
  output logic                        busy,
  output logic                        pt_valid,
  input  logic                        pt_ready,
  output logic [XW-1:0]               pt_x,
  output logic [YW-1:0]               pt_y,
  output logic [brr_pkg::COLOR_W-1:0] pt_col,
  output logic                        pt_last
);

  localparam int CW = brr_pkg::COORD_W;
  localparam int SW = brr_pkg::SIZE_W;

  brr_pkg::brr_state_t state, state_next, start_state;

  logic [SW-1:0] outer_count, outer_count_next;
  logic [SW-1:0] inner_count, inner_count_next;
  logic [XW-1:0] base_x;
  logic [YW-1:0] base_y;
  logic [SW-1:0] size_w, size_h, border_thick;
  logic [brr_pkg::COLOR_W-1:0] border_col, inner_col;
  logic fill_on;

  logic acc, is_start, step_fire;
  logic [CW-1:0] x16, y16;
  logic [SW-1:0] w_minus_t;
  logic [SW:0]   w_minus_2t, h_minus_2t, outer_inc;

  function automatic logic rows_ok(logic [SW-1:0] w, logic [SW-1:0] t);
    return (t != '0) && (w >= t);
  endfunction

  function automatic logic fill_ok(logic f, logic [SW-1:0] w, logic [SW-1:0] h,
                                   logic [SW-1:0] t);
    return f && ({1'b0, w} >= {t, 1'b0}) && ({1'b0, h} >= {t, 1'b0});
  endfunction

  assign busy      = (state != brr_pkg::ST_IDLE);
  assign cmd.ready = !pt_valid || pt_ready;
  assign acc       = cmd.valid && cmd.ready;
  assign is_start  = (cmd.data.op == brr_pkg::OP_START);
  assign step_fire = acc && !is_start && busy;

  // Group entry for a fresh rectangle.
  always_comb begin
    if (cmd.data.edge_width_in != '0) begin
      start_state = brr_pkg::ST_LEFT;
    end else if (fill_ok(cmd.data.fill_in, cmd.data.rect_w_in, cmd.data.rect_h_in,
                         cmd.data.edge_width_in)) begin
      start_state = brr_pkg::ST_FILL;
    end else begin
      start_state = brr_pkg::ST_IDLE;
    end
  end

  assign w_minus_t  = size_w - border_thick;
  assign w_minus_2t = {1'b0, size_w} - {border_thick, 1'b0};
  assign h_minus_2t = {1'b0, size_h} - {border_thick, 1'b0};
  assign outer_inc  = {1'b0, outer_count} + (SW+1)'(1);

  // Advance the walk by one pixel.
  always_comb begin
    state_next       = state;
    outer_count_next = outer_count;
    inner_count_next = inner_count;
    case (state)
      brr_pkg::ST_LEFT: begin
        if (inner_count < size_h) begin
          inner_count_next = inner_count + SW'(1);
        end else begin
          state_next       = brr_pkg::ST_RIGHT;
          inner_count_next = '0;
        end
      end
      brr_pkg::ST_RIGHT: begin
        if (inner_count < size_h) begin
          inner_count_next = inner_count + SW'(1);
        end else if (outer_inc < {1'b0, border_thick}) begin
          outer_count_next = outer_inc[SW-1:0];
          inner_count_next = '0;
          state_next       = brr_pkg::ST_LEFT;
        end else begin
          outer_count_next = '0;
          inner_count_next = '0;
          if (rows_ok(size_w, border_thick)) begin
            state_next = brr_pkg::ST_TOP;
          end else if (fill_ok(fill_on, size_w, size_h, border_thick)) begin
            state_next = brr_pkg::ST_FILL;
          end else begin
            state_next = brr_pkg::ST_IDLE;
          end
        end
      end
      brr_pkg::ST_TOP: begin
        if (inner_count < w_minus_t) begin
          inner_count_next = inner_count + SW'(1);
        end else begin
          state_next       = brr_pkg::ST_BOTTOM;
          inner_count_next = '0;
        end
      end
      brr_pkg::ST_BOTTOM: begin
        if (inner_count < w_minus_t) begin
          inner_count_next = inner_count + SW'(1);
        end else if (outer_inc < {1'b0, border_thick}) begin
          outer_count_next = outer_inc[SW-1:0];
          inner_count_next = '0;
          state_next       = brr_pkg::ST_TOP;
        end else begin
          outer_count_next = '0;
          inner_count_next = '0;
          if (fill_ok(fill_on, size_w, size_h, border_thick)) begin
            state_next = brr_pkg::ST_FILL;
          end else begin
            state_next = brr_pkg::ST_IDLE;
          end
        end
      end
      brr_pkg::ST_FILL: begin
        if ({1'b0, inner_count} < h_minus_2t) begin
          inner_count_next = inner_count + SW'(1);
        end else if ({1'b0, outer_count} < w_minus_2t) begin
          outer_count_next = outer_count + SW'(1);
          inner_count_next = '0;
        end else begin
          state_next = brr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Pixel coordinate, wrapping at 16 bits.
  always_comb begin
    case (state)
      brr_pkg::ST_LEFT: begin
        x16 = CW'(base_x) + CW'(outer_count);
        y16 = CW'(base_y) + CW'(inner_count);
      end
      brr_pkg::ST_RIGHT: begin
        x16 = CW'(base_x) + CW'(size_w) - CW'(outer_count);
        y16 = CW'(base_y) + CW'(inner_count);
      end
      brr_pkg::ST_TOP: begin
        x16 = CW'(base_x) + CW'(inner_count) + CW'(border_thick);
        y16 = CW'(base_y) + CW'(outer_count);
      end
      brr_pkg::ST_BOTTOM: begin
        x16 = CW'(base_x) + CW'(inner_count) + CW'(border_thick);
        y16 = CW'(base_y) + CW'(size_h) - CW'(outer_count);
      end
      default: begin
        x16 = CW'(base_x) + CW'(outer_count) + CW'(border_thick);
        y16 = CW'(base_y) + CW'(inner_count) + CW'(border_thick);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= brr_pkg::ST_IDLE;
      outer_count <= '0;
      inner_count <= '0;
      pt_valid    <= 1'b0;
    end else begin
      if (acc && is_start) begin
        state       <= start_state;
        outer_count <= '0;
        inner_count <= '0;
      end else if (step_fire) begin
        state       <= state_next;
        outer_count <= outer_count_next;
        inner_count <= inner_count_next;
      end
      if (step_fire) begin
        pt_valid <= 1'b1;
      end else if (pt_ready) begin
        pt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_start) begin
      base_x       <= (cmd.data.origin_x_in >= CW'(SCREEN_W)) ? '0 : XW'(cmd.data.origin_x_in);
      base_y       <= (cmd.data.origin_y_in >= CW'(SCREEN_H)) ? '0 : YW'(cmd.data.origin_y_in);
      size_w       <= cmd.data.rect_w_in;
      size_h       <= cmd.data.rect_h_in;
      border_thick <= cmd.data.edge_width_in;
      border_col   <= cmd.data.edge_color_in;
      inner_col    <= cmd.data.interior_color_in;
      fill_on      <= cmd.data.fill_in;
    end
    if (step_fire) begin
      // Force off-screen coordinates to 0.
      pt_x    <= (x16 >= CW'(SCREEN_W)) ? '0 : XW'(x16);
      pt_y    <= (y16 >= CW'(SCREEN_H)) ? '0 : YW'(y16);
      pt_col  <= (state == brr_pkg::ST_FILL) ? inner_col : border_col;
      pt_last <= (state_next == brr_pkg::ST_IDLE);
    end
  end

endmodule

### src/brr_addr_stage.sv
// Address stage: framebuffer address multiply and output register.
module brr_addr_stage #(
  parameter int SCREEN_W = brr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = brr_pkg::SCREEN_H_DEF,
  localparam int XW = $clog2(SCREEN_W),
  localparam int YW = $clog2(SCREEN_H)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pt_valid,
  output logic                        pt_ready,
  input  logic [XW-1:0]               pt_x,
  input  logic [YW-1:0]               pt_y,
  input  logic [brr_pkg::COLOR_W-1:0] pt_col,
  input  logic                        pt_last,
  brr_pix_if.source                   pix
);

  localparam int AW    = $clog2(SCREEN_H * (SCREEN_W + 1));
  localparam int PITCH = SCREEN_W + 1;

  logic [AW-1:0] addr;

  assign addr     = AW'(pt_y) * AW'(PITCH) + AW'(pt_x);
  assign pt_ready = !pix.valid || pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (pt_ready) begin
      pix.valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_ready && pt_valid) begin
      pix.data.pix_x     <= brr_pkg::PIX_X_W'(pt_x);
      pix.data.pix_y     <= brr_pkg::PIX_Y_W'(pt_y);
      pix.data.pix_addr  <= brr_pkg::PIX_ADDR_W'(addr);
      pix.data.pix_color <= pt_col;
      pix.data.last      <= pt_last;
    end
  end

endmodule
